// ===== hw/rtl/sample_playback_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// sample playback resampler assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_RESAMPLER_MACROS_SVH
`define SAMPLE_PLAYBACK_RESAMPLER_MACROS_SVH

// same-cycle implication
`define SPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// shared types and constants of the sample playback resampler
// ----------------------------------------------------------------------------
package spr_pkg;

  // default geometry
  localparam int unsigned SampleDepth = 4096;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned FracBits    = 10;

  // fixed field widths
  localparam int unsigned LenW    = 13;
  localparam int unsigned StepW   = 22;
  localparam int unsigned MixW    = 32;
  localparam int unsigned AddrInW = 12;
  localparam int unsigned CfgW    = StepW;

  // register reset values
  localparam logic [StepW-1:0] StepReset = 22'd1024;
  localparam logic [LenW-1:0]  LenReset  = 13'd0;

  // configuration register indexes
  typedef enum logic {
    CFG_PHASE_STEP    = 1'b0,
    CFG_SAMPLE_LENGTH = 1'b1
  } cfg_idx_e;

  // operation codes of an input word
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_PLAY  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

endpackage

// ===== hw/rtl/sample_playback_resampler.sv =====
// A result word passes a read stage and the output register after its input
// word is accepted, and back-pressure at the output can hold it in either.
// Throughput: one word per cycle while the output does not stall; the phase
// update is one add and compare, the sample one synchronous sample memory read.
// Reset: playback stopped, phase zero, phase_step 1024, sample_length 0;
// the sample memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// sample_playback_resampler
// phase-accumulator sample player with nearest-neighbour resampling
// ----------------------------------------------------------------------------
`include "sample_playback_resampler_macros.svh"

module sample_playback_resampler #(
  parameter int unsigned SAMPLE_DEPTH = spr_pkg::SampleDepth,
  parameter int unsigned SAMPLE_WIDTH = spr_pkg::SampleWidth,
  parameter int unsigned FRAC_BITS    = spr_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [spr_pkg::CfgW-1:0]           cfg_wdata_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [spr_pkg::AddrInW-1:0]        sample_addr_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_value_i,
  input  logic                               loop_mode_i,
  input  logic signed [spr_pkg::MixW-1:0]    mix_in_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spr_pkg::MixW-1:0]    mix_out_o,
  output logic                               was_active_o,
  output logic                               playing_o
);

  // SAMPLE_DEPTH is taken as a power of two: addresses wrap by truncation
  localparam int unsigned AddrW  = $clog2(SAMPLE_DEPTH);
  localparam int unsigned LenW   = spr_pkg::LenW;
  localparam int unsigned StepW  = spr_pkg::StepW;
  localparam int unsigned MixW   = spr_pkg::MixW;
  localparam int unsigned PhaseW = LenW + FRAC_BITS;
  localparam int unsigned WideW  = AddrW + PhaseW + spr_pkg::AddrInW;

  // configuration registers
  logic [StepW-1:0] phase_step_q;
  logic [LenW-1:0]  sample_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q    <= spr_pkg::StepReset;
      sample_length_q <= spr_pkg::LenReset;
    end else if (cfg_we_i) begin
      case (spr_pkg::cfg_idx_e'(cfg_idx_i))
        spr_pkg::CFG_PHASE_STEP:    phase_step_q    <= cfg_wdata_i[StepW-1:0];
        spr_pkg::CFG_SAMPLE_LENGTH: sample_length_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic s2_load, s1_advance, in_accept;

  assign s2_load    = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && s2_load;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_accept  = in_valid_i && in_ready_o;

  // decode of the accepted word
  spr_pkg::func_e func;
  logic           is_write, is_tick;

  assign func     = spr_pkg::func_e'(func_i);
  assign is_write = (func == spr_pkg::FUNC_WRITE);
  assign is_tick  = (func == spr_pkg::FUNC_TICK);

  // playback state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              is_playing_q, is_playing_d;
  logic              is_looping_q, is_looping_d;
  logic              tick_active;
  logic [PhaseW-1:0] phase_sum, loop_size;
  logic              past_end;

  assign tick_active = is_tick && is_playing_q && (sample_length_q != '0);
  assign phase_sum   = phase_q + PhaseW'(phase_step_q);
  assign loop_size   = {sample_length_q, {FRAC_BITS{1'b0}}};
  assign past_end    = (phase_sum >= loop_size);

  // next state for one word
  always_comb begin
    phase_d      = phase_q;
    is_playing_d = is_playing_q;
    is_looping_d = is_looping_q;
    case (func)
      spr_pkg::FUNC_WRITE,
      spr_pkg::FUNC_STOP: begin
        is_playing_d = 1'b0;
        is_looping_d = 1'b0;
      end
      spr_pkg::FUNC_PLAY: begin
        if (!is_playing_q) begin
          is_playing_d = 1'b1;
          is_looping_d = loop_mode_i;
          phase_d      = '0;
        end
      end
      spr_pkg::FUNC_TICK: begin
        if (tick_active) begin
          phase_d = phase_sum;
          if (past_end) begin
            if (is_looping_q) begin
              phase_d = phase_sum - loop_size;
            end else begin
              is_playing_d = 1'b0;
              is_looping_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      is_playing_q <= 1'b0;
      is_looping_q <= 1'b0;
    end else if (in_accept) begin
      phase_q      <= phase_d;
      is_playing_q <= is_playing_d;
      is_looping_q <= is_looping_d;
    end
  end

  // sample memory addresses, wrapped to the memory depth
  logic [WideW-1:0] waddr_wide, raddr_wide;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic signed [SAMPLE_WIDTH-1:0] mem_rdata;

  assign waddr_wide = WideW'(sample_addr_i);
  assign raddr_wide = WideW'(phase_q) >> FRAC_BITS;
  assign mem_waddr  = waddr_wide[AddrW-1:0];
  assign mem_raddr  = raddr_wide[AddrW-1:0];

  spr_sample_mem #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (in_accept && is_write),
    .waddr_i(mem_waddr),
    .wdata_i(sample_value_i),
    .re_i   (in_accept && tick_active),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // stage 1: word waits for the memory read
  logic                   s1_tick_q, s1_active_q, s1_playing_q;
  logic signed [MixW-1:0] s1_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tick_q    <= is_tick;
      s1_active_q  <= tick_active;
      s1_playing_q <= is_playing_d;
      s1_mix_q     <= mix_in_i;
    end
  end

  // stage 2: output register
  logic signed [MixW-1:0] sample_ext, mix_out_d;
  logic signed [MixW-1:0] mix_out_q;
  logic                   was_active_q, playing_q;

  assign sample_ext = MixW'(mem_rdata);

  always_comb begin
    mix_out_d = '0;
    if (s1_tick_q) begin
      mix_out_d = s1_active_q ? (s1_mix_q + sample_ext) : s1_mix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      mix_out_q    <= mix_out_d;
      was_active_q <= s1_active_q;
      playing_q    <= s1_playing_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mix_out_o    = mix_out_q;
  assign was_active_o = was_active_q;
  assign playing_o    = playing_q;

  // checks
  `SPR_ASSERT_NOW(a_loop_needs_play, is_looping_q, is_playing_q,
                  "looping flag set while not playing")
  `SPR_ASSERT_NEXT(a_write_stops, in_accept && is_write, !is_playing_q && !is_looping_q,
                   "sample write did not stop playback")
  `SPR_ASSERT_NEXT(a_idle_phase_holds, in_accept && is_tick && !tick_active,
                   $stable(phase_q), "phase moved on an idle tick")
  `SPR_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s2_load, s1_valid_q,
                   "stage 1 word lost while the output stalled")

endmodule

// ===== hw/rtl/spr_sample_mem.sv =====
// ----------------------------------------------------------------------------
// spr_sample_mem
// single-port-write, single-port-read sample store with registered read data
// ----------------------------------------------------------------------------
module spr_sample_mem #(
  parameter int unsigned SAMPLE_DEPTH = spr_pkg::SampleDepth,
  parameter int unsigned SAMPLE_WIDTH = spr_pkg::SampleWidth,
  localparam int unsigned AddrW = $clog2(SAMPLE_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic signed [SAMPLE_WIDTH-1:0] rdata_o
);

  logic signed [SAMPLE_WIDTH-1:0] mem_q [SAMPLE_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
